// ----- src/etfp_pkg.sv -----
`default_nettype none
package etfp_pkg;

    // fixed field widths
    localparam int PIX_W  = 10;
    localparam int CNT_W  = 16;
    localparam int FX_W   = 32;
    localparam int MUL_W  = FX_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CFG_IDX_W = 3;

    // mapping divider sizing (span up to 4095, |dx| up to 2047)
    localparam int DX_W   = 13;
    localparam int FRAC_SHIFT = 40;
    localparam int NUM_W  = 13 + FRAC_SHIFT;
    localparam int DEN_W  = FX_W + 12;
    localparam int DIV_CNT_W = 6;

    localparam int DEF_WIDTH  = 1024;
    localparam int DEF_HEIGHT = 1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_RE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFS_IM   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_RE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_JULIA_IM = 3'd6;

    // fractal modes
    localparam logic [1:0] MODE_SHIP  = 2'd0;
    localparam logic [1:0] MODE_JULIA = 2'd1;
    localparam logic [1:0] MODE_MANDEL = 2'd2;

    // clamp a wide signed value to signed 32 bits
    function automatic logic signed [FX_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'(32'sh7fffffff);
        lo = -(PROD_W'(33'sh080000000));
        if (v > hi) begin
            sat32 = 32'sh7fffffff;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[FX_W-1:0];
        end
    endfunction

    // absolute value, most negative clamps to most positive
    function automatic logic signed [FX_W-1:0] abs32(input logic signed [FX_W-1:0] v);
        if (v == 32'sh80000000) begin
            abs32 = 32'sh7fffffff;
        end else if (v < 0) begin
            abs32 = -v;
        end else begin
            abs32 = v;
        end
    endfunction

endpackage
`default_nettype wire

// ----- src/etfp_mul.sv -----
`default_nettype none
module etfp_mul (
    input  wire                                   i_clk,
    input  wire logic signed [etfp_pkg::MUL_W-1:0]  i_a,
    input  wire logic signed [etfp_pkg::MUL_W-1:0]  i_b,
    output logic signed [etfp_pkg::PROD_W-1:0]      o_p
);
    import etfp_pkg::*;

    // shared signed multiplier, product registered
    always_ff @(posedge i_clk) begin
        o_p <= i_a * i_b;
    end

endmodule
`default_nettype wire

// ----- src/escape_time_fractal_pixel.sv -----
// Flow: two coordinate maps (multiply, 53-step restoring divide, offset add; the divide
//   is skipped at zero zoom), then init, the iterations and the output state.
// Throughput: one pixel at a time; the next beat is taken after the result leaves.
//   Each iteration reuses one 33x33 multiplier for five products.
// Reset (synchronous, active low) returns the sequencer to idle and loads the
//   register defaults: mandelbrot, limit 64, zoom 1.0, zero offsets and constant.
`default_nettype none
module escape_time_fractal_pixel #(
    parameter int WIDTH  = etfp_pkg::DEF_WIDTH,
    parameter int HEIGHT = etfp_pkg::DEF_HEIGHT
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_valid,
    output logic                                   o_stall,
    input  wire [etfp_pkg::PIX_W-1:0]              i_pixel_x,
    input  wire [etfp_pkg::PIX_W-1:0]              i_pixel_y,
    output logic                                   o_valid,
    input  wire                                    i_stall,
    output logic [etfp_pkg::PIX_W-1:0]             o_out_x,
    output logic [etfp_pkg::PIX_W-1:0]             o_out_y,
    output logic [etfp_pkg::CNT_W-1:0]             o_iteration_count,
    output logic                                   o_inside_set,
    input  wire                                    i_cfg_we,
    input  wire [etfp_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire [etfp_pkg::FX_W-1:0]               i_cfg_data
);
    import etfp_pkg::*;

    localparam int WD = WIDTH - 1;
    localparam int HD = HEIGHT - 1;

    typedef enum logic [14:0] {
        ST_IDLE = 15'h0001,
        ST_DEN  = 15'h0002,
        ST_DIVI = 15'h0004,
        ST_DIV  = 15'h0008,
        ST_OFS  = 15'h0010,
        ST_INIT = 15'h0020,
        ST_ABS  = 15'h0040,
        ST_M0   = 15'h0080,
        ST_M1   = 15'h0100,
        ST_M2   = 15'h0200,
        ST_M3   = 15'h0400,
        ST_M4   = 15'h0800,
        ST_M5   = 15'h1000,
        ST_M6   = 15'h2000,
        ST_OUT  = 15'h4000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [1:0]              r_mode;
    logic [CNT_W-1:0]        r_max;
    logic [FX_W-1:0]         r_zoom;
    logic signed [FX_W-1:0]  r_ofs_re, r_ofs_im, r_jre, r_jim;

    // datapath
    logic [PIX_W-1:0]        r_px, r_py;
    logic                    r_axis;
    logic                    r_neg, r_nz, r_zden;
    logic [DEN_W-1:0]        r_den;
    logic [NUM_W-1:0]        r_q;
    logic [DEN_W:0]          r_rem;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic signed [FX_W-1:0]  r_pre, r_pim;
    logic signed [FX_W-1:0]  r_zr, r_zi, r_cr, r_ci, r_a, r_b;
    logic signed [PROD_W-1:0] r_t;
    logic [CNT_W-1:0]        r_iter;
    logic                    r_inside;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    etfp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // pixel offset from center for the axis in work
    logic signed [DX_W-1:0] dx;
    logic [DX_W-1:0]        dx_mag;
    logic [NUM_W-1:0]       num_mag;
    always_comb begin
        if (r_axis) begin
            dx = $signed({{(DX_W-PIX_W){1'b0}}, r_py}) - DX_W'(HD / 2);
        end else begin
            dx = $signed({{(DX_W-PIX_W){1'b0}}, r_px}) - DX_W'(WD / 2);
        end
        dx_mag = dx[DX_W-1] ? DX_W'(-dx) : DX_W'(dx);
        // scale 3 for re, 2 for im, then << 40
        if (r_axis) begin
            num_mag = {dx_mag[DX_W-2:0], 1'b0, {FRAC_SHIFT{1'b0}}};
        end else begin
            num_mag = {(dx_mag + {dx_mag[DX_W-2:0], 1'b0}), {FRAC_SHIFT{1'b0}}};
        end
    end

    // restoring divide step
    logic [DEN_W+1:0] rem_sh;
    logic [DEN_W+1:0] rem_sub;
    logic             rem_ge;
    assign rem_sh  = {r_rem, r_q[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, 1'b0, r_den};
    assign rem_ge  = rem_sh >= {1'b0, 1'b0, r_den};

    // mapped term plus view offset
    logic signed [PROD_W-1:0] term;
    logic signed [PROD_W-1:0] map_sum;
    logic signed [FX_W-1:0]   map_val;
    always_comb begin
        if (r_zden) begin
            if (!r_nz) begin
                term = '0;
            end else if (r_neg) begin
                term = -(PROD_W'(1) <<< FRAC_SHIFT);
            end else begin
                term = PROD_W'(1) <<< FRAC_SHIFT;
            end
        end else if (r_neg) begin
            term = -$signed({{(PROD_W-NUM_W){1'b0}}, r_q});
        end else begin
            term = $signed({{(PROD_W-NUM_W){1'b0}}, r_q});
        end
        map_sum = term + PROD_W'(r_axis ? r_ofs_im : r_ofs_re);
        map_val = sat32(map_sum);
    end

    // z update and escape test
    logic signed [FX_W-1:0] new_re, new_im;
    logic [63:0]            mag2;
    logic                   escaped;
    logic                   ship;
    assign ship    = (r_mode != MODE_JULIA) && (r_mode != MODE_MANDEL);
    assign new_re  = sat32((r_t >>> 24) + PROD_W'(r_cr));
    assign new_im  = sat32((prod >>> 23) + PROD_W'(r_ci));
    assign mag2    = r_t[63:0] + prod[63:0];
    assign escaped = mag2 > (64'd4 << 48);

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DEN: begin
                mul_a = $signed({1'b0, r_zoom});
                mul_b = r_axis ? MUL_W'(HD) : MUL_W'(WD);
            end
            ST_M0: begin
                mul_a = MUL_W'(r_a);
                mul_b = MUL_W'(r_a);
            end
            ST_M1: begin
                mul_a = MUL_W'(r_b);
                mul_b = MUL_W'(r_b);
            end
            ST_M2: begin
                mul_a = MUL_W'(r_a);
                mul_b = MUL_W'(r_b);
            end
            ST_M4: begin
                mul_a = MUL_W'(r_zr);
                mul_b = MUL_W'(r_zr);
            end
            ST_M5: begin
                mul_a = MUL_W'(r_zi);
                mul_b = MUL_W'(r_zi);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_DEN;
            ST_DEN:  n_state = ST_DIVI;
            ST_DIVI: n_state = (prod == '0) ? ST_OFS : ST_DIV;
            ST_DIV:  if (r_cnt == DIV_CNT_W'(1)) n_state = ST_OFS;
            ST_OFS:  n_state = r_axis ? ST_INIT : ST_DEN;
            ST_INIT: n_state = ST_ABS;
            ST_ABS:  n_state = (r_iter < r_max) ? ST_M0 : ST_OUT;
            ST_M0:   n_state = ST_M1;
            ST_M1:   n_state = ST_M2;
            ST_M2:   n_state = ST_M3;
            ST_M3:   n_state = ST_M4;
            ST_M4:   n_state = ST_M5;
            ST_M5:   n_state = ST_M6;
            ST_M6:   n_state = escaped ? ST_OUT : ST_ABS;
            ST_OUT:  if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_MANDEL;
            r_max    <= CNT_W'(64);
            r_zoom   <= 32'd65536;
            r_ofs_re <= '0;
            r_ofs_im <= '0;
            r_jre    <= '0;
            r_jim    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:     r_mode   <= i_cfg_data[1:0];
                REG_MAX_ITER: r_max    <= i_cfg_data[CNT_W-1:0];
                REG_ZOOM:     r_zoom   <= i_cfg_data;
                REG_OFS_RE:   r_ofs_re <= $signed(i_cfg_data);
                REG_OFS_IM:   r_ofs_im <= $signed(i_cfg_data);
                REG_JULIA_RE: r_jre    <= $signed(i_cfg_data);
                REG_JULIA_IM: r_jim    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_px   <= i_pixel_x;
                r_py   <= i_pixel_y;
                r_axis <= 1'b0;
            end
            ST_DIVI: begin
                r_den  <= prod[DEN_W-1:0];
                r_zden <= (prod == '0);
                r_neg  <= dx[DX_W-1];
                r_nz   <= (dx != '0);
                r_q    <= num_mag;
                r_rem  <= '0;
                r_cnt  <= DIV_CNT_W'(NUM_W);
            end
            ST_DIV: begin
                r_rem <= rem_ge ? rem_sub[DEN_W:0] : rem_sh[DEN_W:0];
                r_q   <= {r_q[NUM_W-2:0], rem_ge};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
            end
            ST_OFS: begin
                if (r_axis) begin
                    r_pim <= map_val;
                end else begin
                    r_pre <= map_val;
                end
                r_axis <= 1'b1;
            end
            ST_INIT: begin
                r_iter <= '0;
                if (r_mode == MODE_JULIA) begin
                    r_zr <= r_pre;
                    r_zi <= r_pim;
                    r_cr <= r_jre;
                    r_ci <= r_jim;
                end else begin
                    r_zr <= '0;
                    r_zi <= '0;
                    r_cr <= r_pre;
                    r_ci <= r_pim;
                end
            end
            ST_ABS: begin
                r_a <= ship ? abs32(r_zr) : r_zr;
                r_b <= ship ? abs32(r_zi) : r_zi;
                r_inside <= (r_iter == r_max);
            end
            ST_M1: r_t <= prod;
            ST_M2: r_t <= r_t - prod;
            ST_M3: begin
                r_zr <= new_re;
                r_zi <= new_im;
            end
            ST_M5: r_t <= prod;
            ST_M6: begin
                if (!escaped) begin
                    r_iter <= r_iter + CNT_W'(1);
                end
                r_inside <= 1'b0;
            end
            default: ;
        endcase
    end

    assign o_stall           = (r_state != ST_IDLE);
    assign o_valid           = (r_state == ST_OUT);
    assign o_out_x           = r_px;
    assign o_out_y           = r_py;
    assign o_iteration_count = r_iter;
    assign o_inside_set      = r_inside;

    // checks
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result shown while input open");
    a_inside_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_set) |-> (o_iteration_count == r_max))
        else $error("inside flag without full count");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_iteration_count <= r_max))
        else $error("count beyond limit");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt != '0))
        else $error("divider ran past its last step");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import etfp_pkg::*;

    localparam int CENTER    = 511;      // integer half of (1024 - 1)
    localparam int SPAN      = 1023;
    localparam int IDLE_LIMIT = 40000;   // cycles with no beat on either side

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [CNT_W-1:0] count;
        logic             in_set;
    } t_pixel_result;

    // Scoreboard: keeps its own register copy and the escape-time predictor
    class fractal_scoreboard;
        logic [1:0]       mode;
        logic [CNT_W-1:0] iter_limit;
        logic [31:0]      zoom_q16;
        int               view_re, view_im, seed_re, seed_im;
        t_pixel_result    pending_px[$];
        int               mismatches, checked, noted;

        function new();
            mode = MODE_MANDEL; iter_limit = 64; zoom_q16 = 32'h0001_0000;
            view_re = 0; view_im = 0; seed_re = 0; seed_im = 0;
            mismatches = 0; checked = 0; noted = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
            case (idx)
                REG_MODE:     mode = d[1:0];
                REG_MAX_ITER: iter_limit = d[15:0];
                REG_ZOOM:     zoom_q16 = d;
                REG_OFS_RE:   view_re = d;
                REG_OFS_IM:   view_im = d;
                REG_JULIA_RE: seed_re = d;
                REG_JULIA_IM: seed_im = d;
                default: ;
            endcase
        endfunction

        function int clamp_q824(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return int'(v);
        endfunction

        function int fold_abs(int v);
            if (v == 32'sh80000000) return 32'sh7fffffff;
            return (v < 0) ? -v : v;
        endfunction

        // pixel offset from the center -> Q8.24 coordinate, truncating divide
        function int map_coord(int delta, int scale, int ofs);
            longint num, den, term;
            num = longint'(delta) * scale * (64'sd1 <<< 40);
            den = longint'({32'b0, zoom_q16}) * SPAN;
            if (den == 0)
                term = (num > 0) ? (64'sd1 <<< 40) : ((num < 0) ? -(64'sd1 <<< 40) : 0);
            else
                term = num / den;
            return clamp_q824(term + ofs);
        endfunction

        function t_pixel_result predict(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            t_pixel_result r;
            int pre, pim, zr, zi, cr, ci, nr, ni;
            longint a, b;
            logic [63:0] mag;
            bit ship;
            int unsigned count;
            pre = map_coord(int'(px) - CENTER, 3, view_re);
            pim = map_coord(int'(py) - CENTER, 2, view_im);
            ship = (mode != MODE_JULIA) && (mode != MODE_MANDEL);
            if (mode == MODE_JULIA) begin
                zr = pre; zi = pim; cr = seed_re; ci = seed_im;
            end else begin
                zr = 0; zi = 0; cr = pre; ci = pim;
            end
            count = 0;
            while (count < iter_limit) begin
                if (ship) begin
                    zr = fold_abs(zr); zi = fold_abs(zi);
                end
                a = zr; b = zi;
                nr = clamp_q824(((a * a - b * b) >>> 24) + cr);
                ni = clamp_q824(((a * b) >>> 23) + ci);
                zr = nr; zi = ni;
                mag = 64'(longint'(nr) * nr) + 64'(longint'(ni) * ni);
                if (mag > (64'd4 << 48)) break;
                count++;
            end
            r.px = px; r.py = py; r.count = count[15:0];
            r.in_set = (count == iter_limit);
            return r;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            pending_px.push_back(predict(px, py));
            noted++;
        endfunction

        function void check_result(t_pixel_result got);
            t_pixel_result exp_r;
            checked++;
            if (pending_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d count=%0d inside=%0d",
                             got.px, got.py, got.count, got.in_set);
                return;
            end
            exp_r = pending_px.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d,%0d cnt %0d in %0d, got %0d,%0d cnt %0d in %0d",
                             exp_r.px, exp_r.py, exp_r.count, exp_r.in_set,
                             got.px, got.py, got.count, got.in_set);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [PIX_W-1:0]     i_pixel_x = '0;
    logic [PIX_W-1:0]     i_pixel_y = '0;
    logic                 i_stall = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [FX_W-1:0]      i_cfg_data = '0;
    wire                  o_stall, o_valid, o_inside_set;
    wire [PIX_W-1:0]      o_out_x, o_out_y;
    wire [CNT_W-1:0]      o_iteration_count;

    escape_time_fractal_pixel i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_out_x(o_out_x), .o_out_y(o_out_y),
        .o_iteration_count(o_iteration_count), .o_inside_set(o_inside_set),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    fractal_scoreboard sb = new();

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // receiver: result checks, stall pattern, idle watchdog
    int stall_style = 0;
    int stall_timer = 0;
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if (o_valid && !i_stall)
            sb.check_result('{o_out_x, o_out_y, o_iteration_count, o_inside_set});
        if (stall_timer == 0) begin
            stall_style = $urandom_range(0, 2);
            stall_timer = $urandom_range(50, 400);
        end else begin
            stall_timer--;
        end
        case (stall_style)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 3) != 0);
        endcase
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    int burst_left = 0;

    // one register write per cycle; we stays high across a group
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        sb.write_reg(idx, d);
        @(posedge i_clk);
    endtask

    task automatic load_view(logic [1:0] mode, logic [15:0] lim, logic [31:0] zm,
                             int ore, int oim, int jre, int jim);
        write_reg(REG_MODE, {30'b0, mode});
        write_reg(REG_MAX_ITER, {16'b0, lim});
        write_reg(REG_ZOOM, zm);
        write_reg(REG_OFS_RE, ore);
        write_reg(REG_OFS_IM, oim);
        write_reg(REG_JULIA_RE, jre);
        write_reg(REG_JULIA_IM, jim);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // send one pixel beat, with bursts and random gaps in between
    task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        do @(posedge i_clk); while (o_stall);
        sb.note_pixel(px, py);
    endtask

    // pause the sender until every expected result has come back
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_px.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic int rand_q824(int mag);
        return $urandom_range(0, 2 * mag) - mag;
    endfunction

    initial begin
        int n;
        logic [1:0]  mode;
        logic [15:0] lim;
        logic [31:0] zm;
        int ore, oim;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset defaults: corners, edges and center
        send_pixel(0, 0);      send_pixel(1022, 1023);
        send_pixel(511, 511);  send_pixel(0, 1023);
        send_pixel(1022, 0);   send_pixel(300, 700);
        drain();
        // burning ship, julia, undefined mode
        load_view(MODE_SHIP, 30, 32'h0001_0000, -32'sh0080_0000, -32'sh0080_0000, 0, 0);
        send_pixel(200, 300);  send_pixel(600, 100);  send_pixel(1022, 1023);
        drain();
        load_view(MODE_JULIA, 40, 32'h0001_0000, 0, 0, -32'sh00cc_cccd, 32'sh0027_ef9e);
        send_pixel(511, 511);  send_pixel(400, 600);  send_pixel(0, 0);
        drain();
        load_view(2'd3, 20, 32'h0002_0000, 0, 0, 0, 0);
        send_pixel(512, 400);  send_pixel(100, 900);
        drain();
        // zero zoom, zero limit, extreme zooms and offsets
        load_view(MODE_MANDEL, 5, 32'h0, 32'sh0100_0000, 0, 0, 0);
        send_pixel(511, 511);  send_pixel(0, 0);  send_pixel(1022, 1023);
        drain();
        load_view(MODE_MANDEL, 0, 32'h0001_0000, 0, 0, 0, 0);
        send_pixel(511, 511);  send_pixel(5, 1000);
        drain();
        load_view(MODE_MANDEL, 16, 32'h1, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0);
        send_pixel(511, 511);  send_pixel(1022, 0);
        drain();
        load_view(MODE_JULIA, 16, 32'hffff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                  32'sh7fff_ffff, 32'sh8000_0000);
        send_pixel(1, 1022);
        drain();

        // random views, mostly small limits so the run stays short
        for (int ph = 0; ph < 20; ph++) begin
            mode = $urandom_range(0, 3);
            lim  = $urandom_range(1, 48);
            n    = 90;
            case ($urandom_range(0, 7))
                0: zm = $urandom();
                1: zm = $urandom_range(0, 2) == 0 ? 32'h0 : ($urandom_range(0, 1) ? 32'h1
                                                                            : 32'hffff_ffff);
                2, 3: zm = $urandom_range(32'h0000_4000, 32'h0040_0000);
                default: zm = 32'h0001_0000 + $urandom_range(0, 32'h0000_ffff);
            endcase
            if ($urandom_range(0, 4) == 0) begin
                ore = $urandom(); oim = $urandom();
            end else begin
                ore = rand_q824(32'h0200_0000); oim = rand_q824(32'h0200_0000);
            end
            if (ph == 7) begin
                lim = 255; n = 40;
            end
            if (ph == 13) begin
                // full limit, view pushed far out so every pixel escapes at once
                lim = 16'hffff; n = 30; ore = 32'sh7fff_ffff; oim = 0; zm = 32'h0001_0000;
            end
            load_view(mode, lim, zm, ore, oim, rand_q824(32'h0180_0000),
                      $urandom_range(0, 9) == 0 ? int'($urandom()) : rand_q824(32'h0180_0000));
            repeat (n) send_pixel($urandom_range(0, 1022), $urandom_range(0, 1023));
            drain();
        end

        repeat (100) @(posedge i_clk);
        $display("covered %0d pixels over 28 register settings, all four mode codes,", sb.noted);
        $display("zoom and offset extremes and limits from 0 to 65535; %0d results checked",
                 sb.checked);
        if (sb.mismatches == 0 && sb.pending_px.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_px.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire
